@@ rtl/core/sgd_pkg.sv @@
package sgd_pkg;

  // fixed widths of the register file and the result fields
  localparam int NUM_COEFF = 7;
  localparam int COEFF_W   = 18;
  localparam int HALF_W    = 3;
  localparam int OUT_W     = 40;
  localparam int BEAT_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = COEFF_W;

  // headroom for a sum of up to seven products
  localparam int SUM_GROWTH = 3;

  // register indexes; coefficient d sits at index REG_COEFF_FIRST + d - 1
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_FIRST = 3'd1;

  // register reset values
  localparam logic [HALF_W-1:0]         WINDOW_HALF_RST = 3'd2;
  localparam logic signed [COEFF_W-1:0] COEFF1_RST      = 18'sd43691;
  localparam logic signed [COEFF_W-1:0] COEFF2_RST      = -18'sd5461;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  // per-item control that travels with the data through the pipe
  typedef struct packed {
    logic              has_value;    // first beat carries the filter sum
    logic              record_last;  // item closes the record
    logic [BEAT_W-1:0] beats;        // result beats caused by this item
  } sgd_ctl_t;

endpackage

@@ rtl/core/sgd_tap_select.sv @@
module sgd_tap_select
  import sgd_pkg::*;
#(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          record_end,
  input  logic [HALF_W-1:0]             window_half,
  output logic                          s1_valid,
  input  logic                          s1_ready,
  output logic signed [SAMPLE_BITS:0]   diff [MAX_HALF],
  output sgd_ctl_t                      ctl
);

  localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int POS_MAX   = 2 * MAX_HALF + 1;
  localparam int POS_W     = $clog2(POS_MAX + 1);
  localparam int DIFF_W    = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] window      [WIN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] window_next [WIN_DEPTH];
  logic signed [DIFF_W-1:0]      diff_next   [MAX_HALF];
  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              pos_next;
  logic [HALF_W-1:0]             h_eff;
  logic [HALF_W-1:0]             pend;
  logic                          regular;
  logic                          full;
  logic                          fire;
  sgd_ctl_t                      ctl_next;

  assign in_ready = !s1_valid || s1_ready;
  assign fire     = in_valid && in_ready;

  // clamp the half width to what the window can hold
  assign h_eff = (window_half > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : window_half;

  // window after the new sample shifts in, newest at tap zero
  always_comb begin
    window_next[0] = sample;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      window_next[i] = window[i - 1];
    end
  end

  // result bookkeeping for this beat
  always_comb begin
    regular  = pos >= POS_W'(h_eff);
    full     = pos >= POS_W'({h_eff, 1'b0});
    if (!record_end) begin
      pend = '0;
    end else if (regular) begin
      pend = h_eff;
    end else begin
      pend = HALF_W'(pos) + HALF_W'(1);
    end
    ctl_next.has_value   = regular;
    ctl_next.record_last = record_end;
    ctl_next.beats       = BEAT_W'(regular) + BEAT_W'(pend);
    if (record_end) begin
      pos_next = '0;
    end else if (pos < POS_W'(POS_MAX)) begin
      pos_next = pos + POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  // antisymmetric tap pairs around the window center
  always_comb begin
    logic [WIN_IDX_W-1:0] lo_idx;
    logic [WIN_IDX_W-1:0] hi_idx;
    for (int l = 0; l < MAX_HALF; l++) begin
      lo_idx = WIN_IDX_W'(h_eff) - WIN_IDX_W'(l + 1);
      hi_idx = WIN_IDX_W'(h_eff) + WIN_IDX_W'(l + 1);
      if (full && (HALF_W'(l) < h_eff)) begin
        diff_next[l] = DIFF_W'(window_next[lo_idx]) - DIFF_W'(window_next[hi_idx]);
      end else begin
        diff_next[l] = '0;
      end
    end
  end

  // stage valid and record position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pos      <= '0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
        pos      <= pos_next;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // window and stage payload
  always_ff @(posedge clk) begin
    if (fire) begin
      window <= window_next;
      diff   <= diff_next;
      ctl    <= ctl_next;
    end
  end

  a_end_clears_pos: assert property (@(posedge clk) disable iff (rst)
    fire && record_end |=> pos == '0)
    else $error("record position not cleared after record end");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(POS_MAX))
    else $error("record position past saturation");

endmodule

@@ rtl/core/sgd_mac.sv @@
module sgd_mac
  import sgd_pkg::*;
#(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic signed [SAMPLE_BITS:0]                           diff [MAX_HALF],
  input  sgd_ctl_t                                              in_ctl,
  input  coeff_t                                                coeff [NUM_COEFF],
  output logic                                                  out_valid,
  input  logic                                                  out_ready,
  output logic signed [SAMPLE_BITS+COEFF_W+SUM_GROWTH:0]        sum,
  output sgd_ctl_t                                              out_ctl
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + COEFF_W;
  localparam int ACC_W  = PROD_W + SUM_GROWTH;

  logic signed [PROD_W-1:0] prod      [MAX_HALF];
  logic signed [PROD_W-1:0] prod_next [MAX_HALF];
  logic signed [ACC_W-1:0]  sum_next;
  logic                     s2_valid;
  logic                     s2_ready;
  sgd_ctl_t                 s2_ctl;

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s2_valid || s2_ready;

  // one multiplier per tap pair
  always_comb begin
    for (int l = 0; l < MAX_HALF; l++) begin
      prod_next[l] = PROD_W'(diff[l]) * PROD_W'(coeff[l]);
    end
  end

  // sum of the registered products
  always_comb begin
    sum_next = '0;
    for (int l = 0; l < MAX_HALF; l++) begin
      sum_next = sum_next + ACC_W'(prod[l]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s2_valid <= 1'b1;
      end else if (s2_ready) begin
        s2_valid <= 1'b0;
      end
      if (s2_valid && s2_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // product and sum registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod   <= prod_next;
      s2_ctl <= in_ctl;
    end
    if (s2_valid && s2_ready) begin
      sum     <= sum_next;
      out_ctl <= s2_ctl;
    end
  end

endmodule

@@ rtl/core/sgd_expand.sv @@
module sgd_expand
  import sgd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic signed [SAMPLE_BITS+COEFF_W+SUM_GROWTH:0] sum,
  input  sgd_ctl_t                                       in_ctl,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [OUT_W-1:0]                        derivative,
  output logic                                           final_result
);

  localparam int ACC_W = SAMPLE_BITS + COEFF_W + SUM_GROWTH + 1;
  localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'({1'b0, {(OUT_W - 1){1'b1}}});
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [EXT_W-1:0] sum_ext;
  logic signed [EXT_W-1:0] sum_clamped;
  logic signed [OUT_W-1:0] x_value;
  logic [BEAT_W-1:0]       x_left;
  logic                    x_has_value;
  logic                    x_last;
  logic                    x_valid;
  logic                    emit;
  logic                    x_done;
  logic                    load;

  // clamp the sum to the result range
  always_comb begin
    sum_ext = EXT_W'(sum);
    if (sum_ext > SAT_HI) begin
      sum_clamped = SAT_HI;
    end else if (sum_ext < SAT_LO) begin
      sum_clamped = SAT_LO;
    end else begin
      sum_clamped = sum_ext;
    end
  end

  // one result beat leaves per cycle while the output register is free
  assign emit     = x_valid && (!out_valid || out_ready);
  assign x_done   = emit && (x_left == BEAT_W'(1));
  assign in_ready = !x_valid || x_done;
  assign load     = in_valid && in_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        x_valid <= in_ctl.beats != '0;
      end else if (x_done) begin
        x_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending item and output register
  always_ff @(posedge clk) begin
    if (emit) begin
      derivative   <= x_has_value ? x_value : '0;
      final_result <= x_last && (x_left == BEAT_W'(1));
    end
    if (load) begin
      x_left      <= in_ctl.beats;
      x_has_value <= in_ctl.has_value;
      x_last      <= in_ctl.record_last;
      x_value     <= sum_clamped[OUT_W-1:0];
    end else if (emit) begin
      x_left      <= x_left - BEAT_W'(1);
      x_has_value <= 1'b0;
    end
  end

  a_pending_has_beats: assert property (@(posedge clk) disable iff (rst)
    x_valid |-> x_left != '0)
    else $error("pending item with no beats left");

  a_final_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_result |-> derivative == '0)
    else $error("record end beat carries a nonzero value");

endmodule

@@ rtl/core/savitzky_golay_derivative.sv @@
// Savitzky-Golay smoothed first derivative, antisymmetric FIR over a record.
// Input channel: in_valid/in_ready with sample and record_end; a beat moves
// on a clock edge where both handshake lines are high. Output channel:
// out_valid/out_ready with derivative (value scaled by 65536) and
// final_result, which marks the last beat of a record.
// Config port: cfg_write, cfg_index, cfg_data; index 0 is window_half,
// indexes 1 to 7 are coeff_1 to coeff_7. Write only while the block is idle.
// Pipeline: an accepted input beat passes the tap select, products, sum,
// expand and output registers before out_valid rises, on top of the
// filter's own delay of window_half samples.
// Throughput, with out_ready high: one input beat per cycle while each
// item makes at most one result; the record end beat makes up to
// window_half + 1 result beats, one per cycle out of the expand stage, while
// the stages ahead of it take up to three more input beats, then in_ready drops.
// Reset: synchronous; clears all valids and the record position and loads
// window_half = 2, coeff_1 = 43691, coeff_2 = -5461, the rest zero.
// Receiver stall: the output register holds its beat, the pipe fills, and
// in_ready drops once every stage holds an item.
module savitzky_golay_derivative
  import sgd_pkg::*;
#(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          record_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       derivative,
  output logic                          final_result
);

  localparam int ACC_W = SAMPLE_BITS + COEFF_W + SUM_GROWTH + 1;

  logic [HALF_W-1:0]          window_half;
  coeff_t                     coeff [NUM_COEFF];
  logic [CFG_IDX_W-1:0]       coeff_idx;
  logic signed [SAMPLE_BITS:0] diff [MAX_HALF];
  sgd_ctl_t                   s1_ctl;
  sgd_ctl_t                   s3_ctl;
  logic signed [ACC_W-1:0]    s3_sum;
  logic                       s1_valid;
  logic                       s1_ready;
  logic                       s3_valid;
  logic                       s3_ready;

  assign coeff_idx = cfg_index - REG_COEFF_FIRST;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_half <= WINDOW_HALF_RST;
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff[i] <= '0;
      end
      coeff[0] <= COEFF1_RST;
      coeff[1] <= COEFF2_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_WINDOW_HALF) begin
        window_half <= cfg_data[HALF_W-1:0];
      end else begin
        coeff[coeff_idx] <= cfg_data;
      end
    end
  end

  // window, tap pairs and record bookkeeping
  sgd_tap_select #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tap_select (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .record_end  (record_end),
    .window_half (window_half),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .diff        (diff),
    .ctl         (s1_ctl)
  );

  // products and their sum
  sgd_mac #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .diff      (diff),
    .in_ctl    (s1_ctl),
    .coeff     (coeff),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .sum       (s3_sum),
    .out_ctl   (s3_ctl)
  );

  // saturation and result beats
  sgd_expand #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_expand (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .in_ready     (s3_ready),
    .sum          (s3_sum),
    .in_ctl       (s3_ctl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .derivative   (derivative),
    .final_result (final_result)
  );

endmodule

@@ tb/savitzky_golay_derivative_checker.sv @@
module savitzky_golay_derivative_checker
  import sgd_pkg::*;
#(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          record_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [OUT_W-1:0]       derivative,
  input  logic                          final_result,
  output int                            mismatches,
  output int                            pending
);

  localparam int TAPS = 2 * MAX_HALF + 1;
  localparam int SHOWN_ERRORS = 10;
  localparam int DUE_DEPTH = 1024;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    closes;
  } deriv_beat_t;

  // shadow of the register file and of the filter state
  logic [HALF_W-1:0]             half_q;
  coeff_t                        coeff_q [NUM_COEFF];
  logic signed [SAMPLE_BITS-1:0] taps_q [TAPS];
  int                            fill_q;
  deriv_beat_t                   due_q [DUE_DEPTH];
  int                            due_head;
  int                            due_count;
  int                            errors;
  int                            beat_no;

  // antisymmetric sum over the current window, saturated to the result width
  function automatic logic signed [OUT_W-1:0] fir_value(input int h);
    longint acc;
    longint lim;
    int d;
    acc = 0;
    lim = (longint'(1) << (OUT_W - 1)) - 1;
    for (d = 1; d <= h; d++) begin
      acc += longint'(coeff_q[d-1]) * (longint'(taps_q[h-d]) - longint'(taps_q[h+d]));
    end
    if (acc > lim) acc = lim;
    if (acc < -lim - 1) acc = -lim - 1;
    return acc[OUT_W-1:0];
  endfunction

  // append one expected beat to the ring of outstanding results
  task automatic stash_beat(input deriv_beat_t b);
    due_q[(due_head + due_count) % DUE_DEPTH] = b;
    due_count++;
  endtask

  // shift one sample in and queue the derivative beats it causes
  task automatic predict_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic closing);
    deriv_beat_t b;
    int h;
    int n;
    int owed;
    int total;
    int i;
    h = int'(half_q);
    if (h > MAX_HALF) h = MAX_HALF;
    n = fill_q;
    for (i = TAPS - 1; i > 0; i--) taps_q[i] = taps_q[i-1];
    taps_q[0] = s;
    owed = (n >= h) ? h : n + 1;
    total = ((n >= h) ? 1 : 0) + (closing ? owed : 0);
    for (i = 0; i < total; i++) begin
      b.value = (i == 0 && n >= h && n >= 2 * h) ? fir_value(h) : '0;
      b.closes = closing && (i == total - 1);
      stash_beat(b);
    end
    if (closing) fill_q = 0;
    else if (n < TAPS) fill_q = n + 1;
  endtask

  always @(posedge clk) begin : track
    deriv_beat_t want;
    int i;
    if (rst) begin
      half_q = WINDOW_HALF_RST;
      for (i = 0; i < NUM_COEFF; i++) coeff_q[i] = '0;
      coeff_q[0] = COEFF1_RST;
      coeff_q[1] = COEFF2_RST;
      for (i = 0; i < TAPS; i++) taps_q[i] = '0;
      fill_q = 0;
      due_head = 0;
      due_count = 0;
    end else begin
      // register writes
      if (cfg_write) begin
        if (cfg_index == REG_WINDOW_HALF) half_q = cfg_data[HALF_W-1:0];
        else coeff_q[cfg_index - REG_COEFF_FIRST] = cfg_data;
      end
      // result beat against the oldest expectation
      if (out_valid && out_ready) begin
        if (due_count == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("derivative beat %0d with nothing expected: %0d last %0b",
                     beat_no, derivative, final_result);
        end else begin
          want = due_q[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_count--;
          if (derivative !== want.value || final_result !== want.closes) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
              $display("derivative beat %0d: expected %0d last %0b, got %0d last %0b",
                       beat_no, want.value, want.closes, derivative, final_result);
          end
        end
        beat_no++;
      end
      // sample beat
      if (in_valid && in_ready) predict_beat(sample, record_end);
    end
    pending    <= due_count;
    mismatches <= errors;
  end

endmodule

@@ tb/savitzky_golay_derivative_tb.sv @@
module savitzky_golay_derivative_tb;
  import sgd_pkg::*;

  localparam int MAX_HALF      = 7;
  localparam int SAMPLE_BITS   = 16;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 28;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coeff_t C_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam coeff_t C_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          record_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [OUT_W-1:0]       derivative;
  logic                          final_result;
  int                            mismatches;
  int                            pending;
  int                            send_idle_pct = 0;
  int                            stall_pct = 0;
  int                            cycles = 0;

  savitzky_golay_derivative #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (.*);

  savitzky_golay_derivative_checker #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (.*);

  always #4 clk = ~clk;

  // receiver with random stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(15))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_length(input int h);
    if ($urandom_range(9) == 0) return $urandom_range(16, 40);
    return $urandom_range(1, 2 * h + 4);
  endfunction

  // one sample beat; valid stays up after acceptance until the next call decides
  task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic closing);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample     <= s;
    record_end <= closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every derivative beat to come out
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_config(input logic [HALF_W-1:0] h, input coeff_t c [NUM_COEFF]);
    int i;
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_HALF;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    for (i = 0; i < NUM_COEFF; i++) begin
      cfg_index <= CFG_IDX_W'(REG_COEFF_FIRST + i);
      cfg_data  <= c[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    coeff_t cset [NUM_COEFF];
    int     seg;
    int     sent;
    int     len;
    int     h;
    int     i;
    logic   paused;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed records under the reset setting: lone sample, short record,
    // full swing record, small values around zero ending in both extremes
    send_beat(S_MAX, 1'b1);
    send_beat(S_MIN, 1'b0);
    send_beat(S_MAX, 1'b0);
    send_beat('1, 1'b1);
    for (i = 0; i < 10; i++) send_beat((i % 2) ? S_MIN : S_MAX, i == 9);
    send_beat('0, 1'b0);
    send_beat('1, 1'b0);
    send_beat(SAMPLE_BITS'(1), 1'b0);
    send_beat(S_MAX, 1'b0);
    send_beat(S_MIN, 1'b1);
    drain(SETTLE_CYCLES);

    // zero half width: one point window, a zero beat per sample
    for (i = 0; i < NUM_COEFF; i++) cset[i] = '0;
    cset[0] = COEFF1_RST;
    cset[1] = COEFF2_RST;
    load_config(HALF_W'(0), cset);
    send_beat(SAMPLE_BITS'(100), 1'b0);
    send_beat(-SAMPLE_BITS'(100), 1'b1);
    send_beat(S_MIN, 1'b1);
    drain(SETTLE_CYCLES);

    // random records, one setting and one idling phase per segment
    paused = 1'b0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          h = MAX_HALF;
          for (i = 0; i < NUM_COEFF; i++) cset[i] = C_MIN;
        end
        1: begin
          h = MAX_HALF;
          for (i = 0; i < NUM_COEFF; i++) cset[i] = C_MAX;
        end
        2: begin
          h = 1;
          for (i = 0; i < NUM_COEFF; i++) cset[i] = COEFF_W'($urandom);
        end
        default: begin
          h = $urandom_range(1, MAX_HALF);
          for (i = 0; i < NUM_COEFF; i++) cset[i] = COEFF_W'($urandom);
        end
      endcase
      load_config(HALF_W'(h), cset);

      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 58; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 58; end
        default: begin send_idle_pct = 9; stall_pct <= 9; end
      endcase

      sent = 0;
      while (sent < SEG_ITEMS) begin
        len = pick_length(h);
        for (i = 0; i < len; i++) begin
          // odd segments leave their last record open across the setting change
          send_beat(pick_sample(),
                    (i == len - 1) && !((seg % 2) && (sent + 1 >= SEG_ITEMS)));
          sent++;
          // sender holds off once until the pipe has emptied
          if (seg == 5 && !paused && sent >= SEG_ITEMS / 2) begin
            paused = 1'b1;
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
          end
        end
      end
      drain(SETTLE_CYCLES);
    end

    drain(2 * SETTLE_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
